// ----- rtl/core/mwh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwh_pkg
// Shared types and constants of the word-serial 32-bit murmur3 hash block.
// ----------------------------------------------------------------------------
package mwh_pkg;

  localparam logic [31:0] SEED_RESET = 32'hc6b568d8;
  localparam logic [31:0] MIX_C1     = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2     = 32'h1b873593;
  localparam logic [31:0] ROUND_ADD  = 32'he6546b64;
  localparam logic [31:0] FIN_M1     = 32'h85ebca6b;
  localparam logic [31:0] FIN_M2     = 32'hc2b2ae35;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  localparam logic [2:0] FULL_COUNT = 3'd4;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  count;
    logic        full;
    logic        last;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL2,
    ST_MIX,
    ST_FIN1,
    ST_FIN2,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic done;
    logic in_msg;
  } back_status_t;

endpackage

// ----- rtl/core/murmur3_word_hash_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmur3_word_hash_top
// 32-bit murmur3 hash of a message arriving as little-endian 32-bit words.
//
//   channel  direction  handshake             payload
//   in       input      in_valid/in_ready     in_data_word, in_byte_count,
//                                             in_last_word
//   out      output     out_valid/out_ready   out_hash_value
//   cfg      input      cfg_valid/cfg_ready   cfg_seed
//
// a non-last word passes back sequencer states IDLE, MUL2 and MIX, and a last
// word also FIN1, FIN2 and DONE, with at most one 32x32 multiply per cycle
// the front takes a beat whenever the two-entry queue has room
// reset sets the seed to its default and starts a fresh message
// a stalled output holds the finished hash while the queue keeps filling
// ----------------------------------------------------------------------------
module murmur3_word_hash_top #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [31:0]  in_data_word,
  input  logic [2:0]   in_byte_count,
  input  logic         in_last_word,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [31:0]  out_hash_value,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_seed
);

  logic [31:0]                  seed_r;
  logic [31:0]                  seed_nxt;
  logic                         q_full;
  logic                         push_valid;
  mwh_pkg::entry_t              push_entry;
  logic                         pop;
  logic                         q_valid;
  mwh_pkg::entry_t              q_entry;
  logic [mwh_pkg::QCNT_W-1:0]   q_level;
  mwh_pkg::back_status_t        bst;

  assign cfg_ready = 1'b1;
  assign seed_nxt  = (cfg_valid && cfg_ready) ? cfg_seed : seed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= mwh_pkg::SEED_RESET;
    end else begin
      seed_r <= seed_nxt;
    end
  end

  mwh_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_word  (in_data_word),
    .in_byte_count (in_byte_count),
    .in_last_word  (in_last_word),
    .q_full        (q_full),
    .push_valid    (push_valid),
    .push_entry    (push_entry)
  );

  mwh_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .pop        (pop),
    .q_full     (q_full),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_level    (q_level)
  );

  mwh_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .seed           (seed_r),
    .q_valid        (q_valid),
    .q_entry        (q_entry),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hash_value (out_hash_value),
    .status         (bst)
  );

`ifndef NO_ASSERTIONS
  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (q_level == mwh_pkg::QCNT_W'(mwh_pkg::QDEPTH)) |-> !in_ready)
    else $error("input taken while queue is full");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (bst.done && out_valid && !out_ready) |=> bst.done)
    else $error("finished hash left the sequencer while output stalled");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ($past(bst.done) && !bst.in_msg))
    else $error("output raised without a finished message");
`endif

endmodule

// ----- rtl/core/mwh_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwh_front
// Accepts input beats and classifies each word as full or tail, masking
// unused tail bytes and saturating the byte count.
// ----------------------------------------------------------------------------
module mwh_front (
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         in_data_word,
  input  logic [2:0]          in_byte_count,
  input  logic                in_last_word,
  input  logic                q_full,
  output logic                push_valid,
  output mwh_pkg::entry_t     push_entry
);

  logic        full;
  logic [31:0] tail_mask;

  always_comb begin
    full = !in_last_word || (in_byte_count >= mwh_pkg::FULL_COUNT);
    case (in_byte_count[1:0])
      2'd0:    tail_mask = 32'h00000000;
      2'd1:    tail_mask = 32'h000000ff;
      2'd2:    tail_mask = 32'h0000ffff;
      2'd3:    tail_mask = 32'h00ffffff;
      default: tail_mask = 32'h00000000;
    endcase
    push_entry.full  = full;
    push_entry.last  = in_last_word;
    push_entry.count = full ? mwh_pkg::FULL_COUNT : {1'b0, in_byte_count[1:0]};
    push_entry.word  = full ? in_data_word : (in_data_word & tail_mask);
  end

  assign in_ready   = !q_full;
  assign push_valid = in_valid && !q_full;

endmodule

// ----- rtl/core/mwh_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwh_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module mwh_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push_valid,
  input  mwh_pkg::entry_t              push_entry,
  input  logic                         pop,
  output logic                         q_full,
  output logic                         q_valid,
  output mwh_pkg::entry_t              q_entry,
  output logic [mwh_pkg::QCNT_W-1:0]   q_level
);

  mwh_pkg::entry_t             mem_r [mwh_pkg::QDEPTH];
  logic [mwh_pkg::QPTR_W-1:0]  wr_ptr_r;
  logic [mwh_pkg::QPTR_W-1:0]  wr_ptr_nxt;
  logic [mwh_pkg::QPTR_W-1:0]  rd_ptr_r;
  logic [mwh_pkg::QPTR_W-1:0]  rd_ptr_nxt;
  logic [mwh_pkg::QCNT_W-1:0]  cnt_r;
  logic [mwh_pkg::QCNT_W-1:0]  cnt_nxt;
  logic                        do_push;
  logic                        do_pop;

  assign q_full  = (cnt_r == mwh_pkg::QCNT_W'(mwh_pkg::QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_entry = mem_r[rd_ptr_r];
  assign q_level = cnt_r;
  assign do_push = push_valid && !q_full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ----- rtl/core/mwh_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwh_back
// Sequencer that scrambles each word, folds it into the running hash and,
// on the last word, runs the finalizer into the output register.
// ----------------------------------------------------------------------------
module mwh_back #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [31:0]            seed,
  input  logic                   q_valid,
  input  mwh_pkg::entry_t        q_entry,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [31:0]            out_hash_value,
  output mwh_pkg::back_status_t  status
);

  mwh_pkg::state_t         state_r;
  mwh_pkg::state_t         state_nxt;
  mwh_pkg::entry_t         item_r;
  mwh_pkg::entry_t         item_nxt;
  logic [31:0]             k_r;
  logic [31:0]             k_nxt;
  logic [31:0]             hash_r;
  logic [31:0]             hash_nxt;
  logic [LENGTH_BITS-1:0]  len_r;
  logic [LENGTH_BITS-1:0]  len_nxt;
  logic [31:0]             f_r;
  logic [31:0]             f_nxt;
  logic                    in_msg_r;
  logic                    in_msg_nxt;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic [31:0]             out_hash_r;
  logic [31:0]             out_hash_nxt;
  logic [31:0]             h0;
  logic [31:0]             hmix;
  logic [31:0]             hrot;
  logic [31:0]             hround;
  logic [LENGTH_BITS-1:0]  len0;
  logic [31:0]             krot;
  logic [31:0]             f16;
  logic [31:0]             f13;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    k_nxt         = k_r;
    hash_nxt      = hash_r;
    len_nxt       = len_r;
    f_nxt         = f_r;
    in_msg_nxt    = in_msg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_hash_nxt  = out_hash_r;
    pop           = 1'b0;

    h0     = in_msg_r ? hash_r : seed;
    len0   = in_msg_r ? len_r : '0;
    hmix   = h0 ^ k_r;
    hrot   = {hmix[18:0], hmix[31:19]};
    hround = (hrot << 2) + hrot + mwh_pkg::ROUND_ADD;
    krot   = {k_r[16:0], k_r[31:17]};
    f16    = f_r ^ (f_r >> 16);
    f13    = f_r ^ (f_r >> 13);

    case (state_r)
      mwh_pkg::ST_IDLE: begin
        if (q_valid) begin
          pop       = 1'b1;
          item_nxt  = q_entry;
          k_nxt     = q_entry.word * mwh_pkg::MIX_C1;
          state_nxt = mwh_pkg::ST_MUL2;
        end
      end
      mwh_pkg::ST_MUL2: begin
        k_nxt     = krot * mwh_pkg::MIX_C2;
        state_nxt = mwh_pkg::ST_MIX;
      end
      mwh_pkg::ST_MIX: begin
        hash_nxt = item_r.full ? hround : h0;
        len_nxt  = len0 + LENGTH_BITS'(item_r.count);
        if (item_r.last) begin
          f_nxt      = hash_nxt ^ (item_r.full ? 32'h0 : k_r) ^ 32'(len_nxt);
          in_msg_nxt = 1'b0;
          state_nxt  = mwh_pkg::ST_FIN1;
        end else begin
          in_msg_nxt = 1'b1;
          state_nxt  = mwh_pkg::ST_IDLE;
        end
      end
      mwh_pkg::ST_FIN1: begin
        f_nxt     = f16 * mwh_pkg::FIN_M1;
        state_nxt = mwh_pkg::ST_FIN2;
      end
      mwh_pkg::ST_FIN2: begin
        f_nxt     = f13 * mwh_pkg::FIN_M2;
        state_nxt = mwh_pkg::ST_DONE;
      end
      mwh_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_hash_nxt  = f16;
          state_nxt     = mwh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mwh_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mwh_pkg::ST_IDLE;
      in_msg_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_msg_r    <= in_msg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    k_r        <= k_nxt;
    hash_r     <= hash_nxt;
    len_r      <= len_nxt;
    f_r        <= f_nxt;
    out_hash_r <= out_hash_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;
  assign status.done    = (state_r == mwh_pkg::ST_DONE);
  assign status.in_msg  = in_msg_r;

endmodule
